### hw/rtl/gcr_pkg.sv
// ============================================================================
// gcr_pkg - shared types and constants of the glyph column rasterizer
// Geometry of the stores, command and write mode codes, the decoded request
// that travels from the front end to the back end, and the register set.
// ============================================================================
package gcr_pkg;

  // Store geometry
  localparam int RING_DEPTH   = 128;
  localparam int RING_W       = $clog2(RING_DEPTH);
  localparam int GLYPH_COUNT  = 256;
  localparam int GI_W         = $clog2(GLYPH_COUNT);
  localparam int BITMAP_DEPTH = 4096;
  localparam int BM_W         = $clog2(BITMAP_DEPTH);
  localparam int MAX_COLUMNS  = 25;
  localparam int SCR_W        = $clog2(MAX_COLUMNS);
  localparam int NC_W         = SCR_W + 1;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QW           = $clog2(QUEUE_DEPTH);

  // Character constants
  localparam logic [7:0]  UTF8_LEAD = 8'hc3;
  localparam logic [7:0]  CH_A_UML  = 8'ha4;
  localparam logic [7:0]  CH_O_UML  = 8'hb6;
  localparam logic [7:0]  CH_U_UML  = 8'hbc;
  localparam logic [7:0]  CH_AU_UML = 8'h84;
  localparam logic [7:0]  CH_OU_UML = 8'h96;
  localparam logic [7:0]  CH_UU_UML = 8'h9c;
  localparam logic [7:0]  CH_ESZETT = 8'h9f;
  localparam logic [7:0]  CH_EIGHT  = 8'h38;
  localparam logic [7:0]  CH_LA     = 8'h61;
  localparam logic [7:0]  CH_LO     = 8'h6f;
  localparam logic [7:0]  CH_LU     = 8'h75;
  localparam logic [7:0]  CH_LS     = 8'h73;
  localparam logic [7:0]  CH_UA     = 8'h41;
  localparam logic [7:0]  CH_UO     = 8'h4f;
  localparam logic [7:0]  CH_UU     = 8'h55;
  localparam logic [7:0]  ROW_BASE  = 8'd11;
  localparam logic [7:0]  MARK_ROW  = 8'd9;
  localparam logic [15:0] BAR_HI    = 16'hfff0;
  localparam logic [15:0] BAR_LO    = 16'h000f;

  // Input command codes
  localparam logic [2:0] CMD_GLYPH  = 3'd0;
  localparam logic [2:0] CMD_BITMAP = 3'd1;
  localparam logic [2:0] CMD_CHAR   = 3'd2;
  localparam logic [2:0] CMD_RAW    = 3'd3;
  localparam logic [2:0] CMD_CURSOR = 3'd4;

  // Column write modes
  localparam logic [1:0] MODE_OVER = 2'd0;
  localparam logic [1:0] MODE_OR   = 2'd1;
  localparam logic [1:0] MODE_ANDN = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_RING_LEN     = 2'd0;
  localparam logic [1:0] REG_FIRST_CODE   = 2'd1;
  localparam logic [1:0] REG_LAST_CODE    = 2'd2;
  localparam logic [1:0] REG_FONT_PRESENT = 2'd3;

  typedef enum logic [2:0] {
    OP_GLYPH,
    OP_BITMAP,
    OP_DRAW,
    OP_RAW,
    OP_CURSOR
  } op_kind_t;

  typedef struct packed {
    logic [11:0]       offset;
    logic [4:0]        width;
    logic [4:0]        height;
    logic [4:0]        advance;
    logic signed [5:0] xoff;
    logic signed [5:0] yoff;
  } glyph_rec_t;

  typedef struct packed {
    op_kind_t          kind;
    logic [11:0]       index;
    glyph_rec_t        rec;
    logic [7:0]        data;
    logic [15:0]       word;
    logic [1:0]        mode;
    logic [GI_W-1:0]   gi;
    logic              marks;
    logic              bar;
  } op_t;

  typedef struct packed {
    logic [7:0] ring_len;
    logic [7:0] first_code;
    logic [7:0] last_code;
    logic       font_present;
  } cfg_t;

  // Bitmap byte address from a 12-bit glyph offset
  function automatic logic [BM_W-1:0] bm_addr(input logic [11:0] off);
    logic [31:0] t;
    t = 32'(off);
    return t[BM_W-1:0];
  endfunction

endpackage

### hw/rtl/gcr_if.sv
// ============================================================================
// gcr_in_if / gcr_out_if - request and column channels
// Valid/ready channels carrying one command request or one written column.
// ============================================================================
interface gcr_in_if;
  logic              valid;
  logic              ready;
  logic [2:0]        command;
  logic [11:0]       index;
  logic [11:0]       bitmap_offset;
  logic [4:0]        glyph_width;
  logic [4:0]        glyph_height;
  logic [4:0]        x_advance;
  logic signed [5:0] x_offset;
  logic signed [5:0] y_offset;
  logic [7:0]        data_byte;
  logic [15:0]       column_word;
  logic [1:0]        write_mode;

  modport source (output valid, command, index, bitmap_offset, glyph_width, glyph_height,
                  x_advance, x_offset, y_offset, data_byte, column_word, write_mode,
                  input ready);
  modport sink (input valid, command, index, bitmap_offset, glyph_width, glyph_height,
                x_advance, x_offset, y_offset, data_byte, column_word, write_mode,
                output ready);
endinterface

interface gcr_out_if;
  logic        valid;
  logic        ready;
  logic [6:0]  column_position;
  logic [15:0] column_value;
  logic        last;

  modport source (output valid, column_position, column_value, last, input ready);
  modport sink (input valid, column_position, column_value, last, output ready);
endinterface

### hw/rtl/glyph_column_rasterizer.sv
// ============================================================================
// glyph_column_rasterizer - text to display column rasterizer
// Holds the configuration registers and joins decoder, queue and executor.
// ============================================================================
// Table loads and cursor sets are done in the executor; rejected
// characters and umlaut lead bytes are dropped by the decoder and never reach
// it. A raw column is a read then write of the ring memory. For a character
// the executor loads the glyph record, fetches each bitmap byte and unpacks
// it one bit per cycle between byte fetches, takes its mark steps (one to
// four) and writes each column as a read then write of the ring memory. A
// stalled column channel holds the column write. A four-entry queue lets
// requests be accepted while a character is drawn.
// The column ring starts all zero after reset; the glyph table and bitmap
// store must be loaded before use.
module glyph_column_rasterizer (
  input  logic       clk,
  input  logic       rst_n,
  gcr_in_if.sink     in_ch,
  gcr_out_if.source  out_ch,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  gcr_pkg::cfg_t cfg_r;
  gcr_pkg::op_t  push_op, pop_op;
  logic          push, pop, full, empty;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ring_len     <= 8'd128;
      cfg_r.first_code   <= 8'd32;
      cfg_r.last_code    <= 8'd126;
      cfg_r.font_present <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        gcr_pkg::REG_RING_LEN:     cfg_r.ring_len     <= cfg_data;
        gcr_pkg::REG_FIRST_CODE:   cfg_r.first_code   <= cfg_data;
        gcr_pkg::REG_LAST_CODE:    cfg_r.last_code    <= cfg_data;
        gcr_pkg::REG_FONT_PRESENT: cfg_r.font_present <= cfg_data[0];
        default:                   cfg_r <= cfg_r;
      endcase
    end
  end

  gcr_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .cfg   (cfg_r),
    .full  (full),
    .push  (push),
    .op    (push_op)
  );

  gcr_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_op (push_op),
    .full    (full),
    .pop     (pop),
    .pop_op  (pop_op),
    .empty   (empty)
  );

  gcr_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .empty  (empty),
    .op     (pop_op),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

### hw/rtl/gcr_front.sv
// ============================================================================
// gcr_front - request decoder
// Accepts requests, folds UTF-8 umlauts, rejects out-of-font characters and
// out-of-range table loads and pushes decoded operations into the queue.
// ============================================================================
module gcr_front (
  input  logic          clk,
  input  logic          rst_n,
  gcr_in_if.sink        in_ch,
  input  gcr_pkg::cfg_t cfg,
  input  logic          full,
  output logic          push,
  output gcr_pkg::op_t  op
);

  logic       pend_r, pend_nxt;
  logic       push_v;
  logic       accept;
  logic [7:0] code;
  logic [7:0] gi8;

  assign in_ch.ready = !full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign push        = accept && push_v;

  // Classify the request
  always_comb begin
    op.kind        = gcr_pkg::OP_RAW;
    op.index       = in_ch.index;
    op.rec.offset  = in_ch.bitmap_offset;
    op.rec.width   = in_ch.glyph_width;
    op.rec.height  = in_ch.glyph_height;
    op.rec.advance = in_ch.x_advance;
    op.rec.xoff    = in_ch.x_offset;
    op.rec.yoff    = in_ch.y_offset;
    op.data        = in_ch.data_byte;
    op.word        = in_ch.column_word;
    op.mode        = in_ch.write_mode;
    op.marks       = 1'b0;
    op.bar         = 1'b0;
    push_v         = 1'b0;
    pend_nxt       = pend_r;
    code           = in_ch.data_byte;
    gi8            = code - cfg.first_code;
    op.gi          = gi8[gcr_pkg::GI_W-1:0];
    case (in_ch.command)
      gcr_pkg::CMD_GLYPH: begin
        op.kind = gcr_pkg::OP_GLYPH;
        push_v  = 32'(in_ch.index) < gcr_pkg::GLYPH_COUNT;
      end
      gcr_pkg::CMD_BITMAP: begin
        op.kind = gcr_pkg::OP_BITMAP;
        push_v  = 32'(in_ch.index) < gcr_pkg::BITMAP_DEPTH;
      end
      gcr_pkg::CMD_CHAR: begin
        op.kind = gcr_pkg::OP_DRAW;
        if (cfg.font_present) begin
          if (in_ch.data_byte == gcr_pkg::UTF8_LEAD) begin
            pend_nxt = 1'b1;
          end else begin
            if (pend_r) begin
              op.marks = 1'b1;
              pend_nxt = 1'b0;
              case (in_ch.data_byte)
                gcr_pkg::CH_A_UML:  code = gcr_pkg::CH_LA;
                gcr_pkg::CH_O_UML:  code = gcr_pkg::CH_LO;
                gcr_pkg::CH_U_UML:  code = gcr_pkg::CH_LU;
                gcr_pkg::CH_AU_UML: code = gcr_pkg::CH_UA;
                gcr_pkg::CH_OU_UML: code = gcr_pkg::CH_UO;
                gcr_pkg::CH_UU_UML: code = gcr_pkg::CH_UU;
                gcr_pkg::CH_ESZETT: begin
                  code   = gcr_pkg::CH_LS;
                  op.bar = 1'b1;
                end
                default: begin
                  code     = gcr_pkg::CH_EIGHT;
                  op.marks = 1'b0;
                end
              endcase
            end
            gi8   = code - cfg.first_code;
            op.gi = gi8[gcr_pkg::GI_W-1:0];
            push_v = (code >= cfg.first_code) && (code <= cfg.last_code) &&
                     (32'(gi8) < gcr_pkg::GLYPH_COUNT);
          end
        end
      end
      gcr_pkg::CMD_RAW: begin
        op.kind = gcr_pkg::OP_RAW;
        push_v  = 1'b1;
      end
      gcr_pkg::CMD_CURSOR: begin
        op.kind = gcr_pkg::OP_CURSOR;
        push_v  = 1'b1;
      end
      default: push_v = 1'b0;
    endcase
  end

  // Hold the umlaut lead flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else if (accept) begin
      pend_r <= pend_nxt;
    end
  end

endmodule

### hw/rtl/gcr_queue.sv
// ============================================================================
// gcr_queue - operation queue
// Small FIFO of decoded operations between the front end and the back end.
// ============================================================================
module gcr_queue (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  gcr_pkg::op_t push_op,
  output logic         full,
  input  logic         pop,
  output gcr_pkg::op_t pop_op,
  output logic         empty
);

  gcr_pkg::op_t            slot_r [gcr_pkg::QUEUE_DEPTH];
  logic [gcr_pkg::QW-1:0]  wp_r, rp_r;
  logic [gcr_pkg::QW:0]    count_r;

  assign full   = 32'(count_r) == gcr_pkg::QUEUE_DEPTH;
  assign empty  = count_r == '0;
  assign pop_op = slot_r[rp_r];

  // Store the pushed operation
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= push_op;
    end
  end

  // Advance the pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      rp_r    <= '0;
      count_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      count_r <= count_r + (gcr_pkg::QW+1)'(push) - (gcr_pkg::QW+1)'(pop);
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= gcr_pkg::QUEUE_DEPTH) else $error("queue count overflow");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty) else $error("pop from empty queue");
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!full || pop)) else $error("push into full queue");
`endif

endmodule

### hw/rtl/gcr_back.sv
// ============================================================================
// gcr_back - glyph table, bitmap store and column ring executor
// Executes queued operations: loads tables, unpacks glyph bits one per cycle
// between byte fetches into the column scratch, draws marks, writes columns.
// ============================================================================
module gcr_back (
  input  logic          clk,
  input  logic          rst_n,
  input  gcr_pkg::cfg_t cfg,
  input  logic          empty,
  input  gcr_pkg::op_t  op,
  output logic          pop,
  gcr_out_if.source     out_ch
);

  typedef enum logic [3:0] {
    S_IDLE, S_GLOAD, S_FETCH, S_LOAD, S_BIT, S_MARK, S_CRD, S_CWR
  } state_t;

  state_t state_r;

  // Memories
  gcr_pkg::glyph_rec_t gt_mem [gcr_pkg::GLYPH_COUNT];
  logic [7:0]          bm_mem [gcr_pkg::BITMAP_DEPTH];
  logic [15:0]         ring_mem [gcr_pkg::RING_DEPTH];
  logic [gcr_pkg::RING_DEPTH-1:0] ring_vld_r;
  gcr_pkg::glyph_rec_t gt_q;
  logic [7:0]          bm_q;
  logic [15:0]         ring_q;

  logic [15:0]              scr_r [gcr_pkg::MAX_COLUMNS];
  gcr_pkg::glyph_rec_t      g_r;
  logic [gcr_pkg::BM_W-1:0] addr_r;
  logic [7:0]               bits_r;
  logic [2:0]               k_r;
  logic [4:0]               xx_r, yy_r;
  logic [1:0]               ms_r;
  logic                     marks_r, bar_r, raw_r;
  logic [1:0]               mode_r;
  logic [15:0]              word_r;
  logic [gcr_pkg::NC_W-1:0] ncols_r;
  logic [gcr_pkg::SCR_W-1:0] ci_r;
  logic [gcr_pkg::RING_W-1:0] cursor_r;

  logic        out_valid_r;
  logic [6:0]  out_pos_r;
  logic [15:0] out_val_r, out_val_nxt;
  logic        out_last_r;

  // Wrap point and next cursor
  logic [gcr_pkg::RING_W:0] wrap;
  logic [gcr_pkg::RING_W:0] cur_inc;
  always_comb begin
    if (cfg.ring_len == 8'd0) wrap = (gcr_pkg::RING_W+1)'(1);
    else if (32'(cfg.ring_len) > gcr_pkg::RING_DEPTH)
      wrap = (gcr_pkg::RING_W+1)'(gcr_pkg::RING_DEPTH);
    else wrap = (gcr_pkg::RING_W+1)'(cfg.ring_len);
    cur_inc = {1'b0, cursor_r} + 1'b1;
  end

  // Glyph record sizing
  logic [5:0] adv1;
  logic [gcr_pkg::NC_W-1:0] ncols_g;
  always_comb begin
    adv1 = {1'b0, gt_q.advance} + 6'd1;
    if (32'(adv1) > gcr_pkg::MAX_COLUMNS) ncols_g = gcr_pkg::NC_W'(gcr_pkg::MAX_COLUMNS);
    else ncols_g = gcr_pkg::NC_W'(adv1);
  end

  // Bit unpack position
  logic signed [7:0] xo_s, yo_s, col_s, row_s, t_s;
  logic              bit_hit, last_x, bits_done;
  always_comb begin
    xo_s    = {{2{g_r.xoff[5]}}, g_r.xoff};
    yo_s    = {{2{g_r.yoff[5]}}, g_r.yoff};
    col_s   = $signed({3'b0, xx_r}) + xo_s;
    row_s   = $signed({3'b0, yy_r}) + $signed(gcr_pkg::ROW_BASE) + yo_s;
    t_s     = $signed(gcr_pkg::MARK_ROW) + yo_s;
    bit_hit = bits_r[7] && !col_s[7] && (col_s < $signed({2'b0, ncols_r})) &&
              !row_s[7] && (row_s <= 8'sd15);
    last_x    = xx_r == g_r.width - 5'd1;
    bits_done = last_x && (yy_r == g_r.height - 5'd1);
  end

  // Mark step: column, mask and operation
  logic signed [7:0] mcol_s;
  logic [15:0]       mmask;
  logic              mand, mark_on, mark_last, mcol_ok;
  always_comb begin
    mark_on = marks_r && !t_s[7] && (t_s <= 8'sd15);
    mand    = 1'b0;
    if (bar_r) begin
      mark_last = ms_r == 2'd1;
      if (ms_r == 2'd0) begin
        mcol_s = xo_s + 8'sd1;
        mmask  = gcr_pkg::BAR_HI << t_s[3:0];
      end else begin
        mcol_s = xo_s + 8'sd2;
        mmask  = gcr_pkg::BAR_LO << t_s[3:0];
        mand   = 1'b1;
      end
    end else begin
      mark_last = ms_r == 2'd3;
      mmask     = 16'd1 << t_s[3:0];
      case (ms_r)
        2'd0:    mcol_s = xo_s;
        2'd1:    mcol_s = xo_s + 8'sd1;
        2'd2:    mcol_s = xo_s + $signed({3'b0, g_r.width}) - 8'sd2;
        default: mcol_s = xo_s + $signed({3'b0, g_r.width}) - 8'sd1;
      endcase
    end
    mcol_ok = !mcol_s[7] && (mcol_s < $signed({2'b0, ncols_r}));
  end

  // Column write
  logic [15:0] col_word, old_val;
  logic        fire, col_last;
  always_comb begin
    col_word = raw_r ? word_r : scr_r[ci_r];
    old_val  = ring_vld_r[cursor_r] ? ring_q : 16'd0;
    case (mode_r)
      gcr_pkg::MODE_OVER: out_val_nxt = col_word;
      gcr_pkg::MODE_OR:   out_val_nxt = old_val | col_word;
      gcr_pkg::MODE_ANDN: out_val_nxt = old_val & ~col_word;
      default:            out_val_nxt = old_val;
    endcase
    fire     = (state_r == S_CWR) && (!out_valid_r || out_ch.ready);
    col_last = gcr_pkg::NC_W'(ci_r) == ncols_r - 1'b1;
  end

  assign pop = (state_r == S_IDLE) && !empty;

  // Glyph table and bitmap store
  always_ff @(posedge clk) begin
    if (pop && op.kind == gcr_pkg::OP_GLYPH) begin
      gt_mem[op.index[gcr_pkg::GI_W-1:0]] <= op.rec;
    end
    gt_q <= gt_mem[op.gi];
  end

  always_ff @(posedge clk) begin
    if (pop && op.kind == gcr_pkg::OP_BITMAP) begin
      bm_mem[op.index[gcr_pkg::BM_W-1:0]] <= op.data;
    end
    bm_q <= bm_mem[addr_r];
  end

  // Column ring
  always_ff @(posedge clk) begin
    if (fire) begin
      ring_mem[cursor_r] <= out_val_nxt;
    end
    ring_q <= ring_mem[cursor_r];
  end

  // Column scratch
  always_ff @(posedge clk) begin
    if (state_r == S_GLOAD) begin
      for (int i = 0; i < gcr_pkg::MAX_COLUMNS; i++) scr_r[i] <= 16'd0;
    end else if (state_r == S_BIT && bit_hit) begin
      scr_r[col_s[gcr_pkg::SCR_W-1:0]] <= scr_r[col_s[gcr_pkg::SCR_W-1:0]] |
                                          (16'd1 << row_s[3:0]);
    end else if (state_r == S_MARK && mark_on && mcol_ok) begin
      if (mand) scr_r[mcol_s[gcr_pkg::SCR_W-1:0]] <= scr_r[mcol_s[gcr_pkg::SCR_W-1:0]] & mmask;
      else      scr_r[mcol_s[gcr_pkg::SCR_W-1:0]] <= scr_r[mcol_s[gcr_pkg::SCR_W-1:0]] | mmask;
    end
  end

  // Sequencer with registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cursor_r    <= '0;
      ring_vld_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (pop) begin
            marks_r <= op.marks;
            bar_r   <= op.bar;
            mode_r  <= op.mode;
            word_r  <= op.word;
            ci_r    <= '0;
            case (op.kind)
              gcr_pkg::OP_DRAW: begin
                raw_r   <= 1'b0;
                state_r <= S_GLOAD;
              end
              gcr_pkg::OP_RAW: begin
                raw_r   <= 1'b1;
                ncols_r <= gcr_pkg::NC_W'(1);
                state_r <= S_CRD;
              end
              gcr_pkg::OP_CURSOR: begin
                if (32'(op.index) >= 32'(wrap)) cursor_r <= '0;
                else cursor_r <= op.index[gcr_pkg::RING_W-1:0];
              end
              default: state_r <= S_IDLE;
            endcase
          end
        end
        S_GLOAD: begin
          g_r     <= gt_q;
          ncols_r <= ncols_g;
          addr_r  <= gcr_pkg::bm_addr(gt_q.offset);
          k_r     <= '0;
          xx_r    <= '0;
          yy_r    <= '0;
          ms_r    <= '0;
          if (gt_q.width == 5'd0 || gt_q.height == 5'd0) state_r <= S_MARK;
          else state_r <= S_FETCH;
        end
        S_FETCH: begin
          addr_r  <= addr_r + 1'b1;
          state_r <= S_LOAD;
        end
        S_LOAD: begin
          bits_r  <= bm_q;
          state_r <= S_BIT;
        end
        S_BIT: begin
          bits_r <= bits_r << 1;
          k_r    <= k_r + 3'd1;
          if (last_x) begin
            xx_r <= '0;
            yy_r <= yy_r + 5'd1;
          end else begin
            xx_r <= xx_r + 5'd1;
          end
          if (bits_done) state_r <= S_MARK;
          else if (k_r == 3'd7) state_r <= S_FETCH;
        end
        S_MARK: begin
          ms_r <= ms_r + 2'd1;
          if (!mark_on || mark_last) state_r <= S_CRD;
        end
        S_CRD: begin
          state_r <= S_CWR;
        end
        S_CWR: begin
          if (fire) begin
            ring_vld_r[cursor_r] <= 1'b1;
            out_valid_r <= 1'b1;
            out_pos_r   <= 7'(cursor_r);
            out_val_r   <= out_val_nxt;
            out_last_r  <= col_last;
            if (cur_inc >= wrap) cursor_r <= '0;
            else cursor_r <= cur_inc[gcr_pkg::RING_W-1:0];
            if (col_last) begin
              state_r <= S_IDLE;
            end else begin
              ci_r    <= ci_r + 1'b1;
              state_r <= S_CRD;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.column_position = out_pos_r;
  assign out_ch.column_value    = out_val_r;
  assign out_ch.last            = out_last_r;

`ifndef NO_ASSERTIONS
  a_out_from_write: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_CWR)) else $error("column without write");
  a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CWR) |-> (gcr_pkg::NC_W'(ci_r) < ncols_r)) else $error("column index range");
  a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_BIT) |-> (yy_r < g_r.height)) else $error("bit row past glyph");
`endif

endmodule

### test/tb_glyph_column_rasterizer.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_glyph_column_rasterizer - self-checking bench of the column rasterizer
// Drives glyph, bitmap, character, raw column and cursor requests through the
// request channel and checks every column written against a behavioral
// prediction kept in a scoreboard, across several register settings and
// different amounts of idling on both channels.
// ============================================================================
module tb_glyph_column_rasterizer;

  localparam logic [1:0] MODE_KEEP  = 2'd3;
  localparam logic [2:0] CMD_BAD    = 3'd7;
  localparam int         DOG_LIMIT  = 20000;
  localparam int         DRAIN_WAIT = 2500;

  typedef struct {
    logic [2:0]        command;
    logic [11:0]       index;
    logic [11:0]       bitmap_offset;
    logic [4:0]        glyph_width;
    logic [4:0]        glyph_height;
    logic [4:0]        x_advance;
    logic signed [5:0] x_offset;
    logic signed [5:0] y_offset;
    logic [7:0]        data_byte;
    logic [15:0]       column_word;
    logic [1:0]        write_mode;
  } request_t;

  typedef struct {
    logic [6:0]  pos;
    logic [15:0] value;
    logic        last;
  } column_t;

  // Column prediction and expected column store
  class column_scoreboard;
    logic [15:0]         ring [gcr_pkg::RING_DEPTH];
    int                  cursor;
    bit                  pending;
    gcr_pkg::glyph_rec_t glyphs [gcr_pkg::GLYPH_COUNT];
    logic [7:0]          bitmap [gcr_pkg::BITMAP_DEPTH];
    bit                  glyph_loaded [gcr_pkg::GLYPH_COUNT];
    bit                  byte_loaded [gcr_pkg::BITMAP_DEPTH];
    logic [15:0]         scratch [gcr_pkg::MAX_COLUMNS];
    int                  ring_len = 128;
    int                  first_code = 32;
    int                  last_code = 126;
    bit                  font_present = 0;
    column_t             columns_due [$];
    int                  errors = 0;

    function new();
      foreach (ring[i]) ring[i] = '0;
      cursor = 0;
      pending = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [7:0] val);
      case (idx)
        gcr_pkg::REG_RING_LEN:     ring_len = val;
        gcr_pkg::REG_FIRST_CODE:   first_code = val;
        gcr_pkg::REG_LAST_CODE:    last_code = val;
        gcr_pkg::REG_FONT_PRESENT: font_present = val[0];
        default: ;
      endcase
    endfunction

    function int wrap_point();
      int pc;
      pc = (ring_len == 0) ? 1 : ring_len;
      return (pc > gcr_pkg::RING_DEPTH) ? gcr_pkg::RING_DEPTH : pc;
    endfunction

    function void put_column(logic [15:0] w, logic [1:0] mode, bit last);
      column_t c;
      if (mode == gcr_pkg::MODE_OVER) ring[cursor] = w;
      else if (mode == gcr_pkg::MODE_OR) ring[cursor] |= w;
      else if (mode == gcr_pkg::MODE_ANDN) ring[cursor] &= ~w;
      c.pos = cursor[6:0];
      c.value = ring[cursor];
      c.last = last;
      columns_due.push_back(c);
      cursor = cursor + 1;
      if (cursor >= wrap_point()) cursor = 0;
    endfunction

    // Map the byte after a lead byte to its base letter
    function logic [7:0] base_letter(logic [7:0] c, output bit marks, output bit bar);
      marks = 1;
      bar = 0;
      case (c)
        gcr_pkg::CH_A_UML:  return gcr_pkg::CH_LA;
        gcr_pkg::CH_O_UML:  return gcr_pkg::CH_LO;
        gcr_pkg::CH_U_UML:  return gcr_pkg::CH_LU;
        gcr_pkg::CH_AU_UML: return gcr_pkg::CH_UA;
        gcr_pkg::CH_OU_UML: return gcr_pkg::CH_UO;
        gcr_pkg::CH_UU_UML: return gcr_pkg::CH_UU;
        gcr_pkg::CH_ESZETT: begin
          bar = 1;
          return gcr_pkg::CH_LS;
        end
        default: begin
          marks = 0;
          return gcr_pkg::CH_EIGHT;
        end
      endcase
    endfunction

    // Glyph number a character would read now, or -1 when it draws nothing
    function int glyph_for(logic [7:0] c);
      bit marks, bar;
      int code;
      if (!font_present || c == gcr_pkg::UTF8_LEAD) return -1;
      code = pending ? base_letter(c, marks, bar) : c;
      if (code < first_code || code > last_code) return -1;
      return code - first_code;
    endfunction

    function void mark_or(int col, int ncols, logic [15:0] m);
      if (col >= 0 && col < ncols) scratch[col] |= m;
    endfunction

    function void draw(logic [7:0] c, logic [1:0] mode);
      bit marks, bar;
      int code, ncols, xo, t, col, row, k, addr;
      gcr_pkg::glyph_rec_t g;
      logic [7:0] bits;
      int hi, lo;
      marks = 0;
      bar = 0;
      if (!font_present) return;
      if (c == gcr_pkg::UTF8_LEAD) begin
        pending = 1;
        return;
      end
      code = c;
      if (pending) begin
        code = base_letter(c, marks, bar);
        pending = 0;
      end
      if (code < first_code || code > last_code) return;
      g = glyphs[code - first_code];
      ncols = int'(g.advance) + 1;
      if (ncols > gcr_pkg::MAX_COLUMNS) ncols = gcr_pkg::MAX_COLUMNS;
      foreach (scratch[i]) scratch[i] = '0;
      xo = g.xoff;
      addr = g.offset;
      k = 0;
      bits = '0;
      // Unpack the bitmap MSB first, one bit per pixel
      for (int yy = 0; yy < g.height; yy++) begin
        for (int xx = 0; xx < g.width; xx++) begin
          if ((k % 8) == 0) begin
            bits = bitmap[addr % gcr_pkg::BITMAP_DEPTH];
            addr++;
          end
          k++;
          col = xx + xo;
          row = yy + 11 + int'(g.yoff);
          if (bits[7] && col >= 0 && col < ncols && row >= 0 && row <= 15)
            scratch[col] |= 16'(1 << row);
          bits = bits << 1;
        end
      end
      // Draw dots or the eszett bar
      t = 9 + int'(g.yoff);
      if (marks && t >= 0 && t <= 15) begin
        if (bar) begin
          hi = (32'hfff0 << t);
          lo = (32'h000f << t);
          mark_or(xo + 1, ncols, hi[15:0]);
          if (xo + 2 >= 0 && xo + 2 < ncols) scratch[xo + 2] &= lo[15:0];
        end else begin
          mark_or(xo, ncols, 16'(1 << t));
          mark_or(xo + 1, ncols, 16'(1 << t));
          mark_or(xo + int'(g.width) - 2, ncols, 16'(1 << t));
          mark_or(xo + int'(g.width) - 1, ncols, 16'(1 << t));
        end
      end
      for (int i = 0; i < ncols; i++) put_column(scratch[i], mode, i == ncols - 1);
    endfunction

    function void note_request(request_t r);
      case (r.command)
        gcr_pkg::CMD_GLYPH: if (r.index < gcr_pkg::GLYPH_COUNT) begin
          glyphs[r.index] = '{r.bitmap_offset, r.glyph_width, r.glyph_height,
                              r.x_advance, r.x_offset, r.y_offset};
          glyph_loaded[r.index] = 1;
        end
        gcr_pkg::CMD_BITMAP: begin
          bitmap[r.index] = r.data_byte;
          byte_loaded[r.index] = 1;
        end
        gcr_pkg::CMD_CHAR:   draw(r.data_byte, r.write_mode);
        gcr_pkg::CMD_RAW:    put_column(r.column_word, r.write_mode, 1);
        gcr_pkg::CMD_CURSOR: cursor = (r.index >= wrap_point()) ? 0 : int'(r.index);
        default: ;
      endcase
    endfunction

    function void check_column(logic [6:0] pos, logic [15:0] value, logic last);
      column_t e;
      if (columns_due.size() == 0) begin
        $display("%0t: unexpected column: expected none, got pos %0d value %h last %b",
                 $time, pos, value, last);
        errors++;
        return;
      end
      e = columns_due.pop_front();
      if (pos !== e.pos || value !== e.value || last !== e.last) begin
        $display("%0t: column mismatch: expected pos %0d value %h last %b,", $time,
                 e.pos, e.value, e.last);
        $display("%0t:   got pos %0d value %h last %b", $time, pos, value, last);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic [1:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;
  int tx_idle = 0;
  int rx_idle = 0;
  int quiet_cycles = 0;
  column_scoreboard sb;

  gcr_in_if in_ch ();
  gcr_out_if out_ch ();

  glyph_column_rasterizer i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch.sink),
    .out_ch   (out_ch.source),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  initial begin
    in_ch.valid = 0;
    in_ch.command = '0;
    in_ch.index = '0;
    in_ch.bitmap_offset = '0;
    in_ch.glyph_width = '0;
    in_ch.glyph_height = '0;
    in_ch.x_advance = '0;
    in_ch.x_offset = '0;
    in_ch.y_offset = '0;
    in_ch.data_byte = '0;
    in_ch.column_word = '0;
    in_ch.write_mode = '0;
    out_ch.ready = 0;
  end

  // Stall the column channel at random and check accepted columns
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_column(out_ch.column_position, out_ch.column_value, out_ch.last);
    out_ch.ready <= ($urandom_range(0, 99) >= rx_idle);
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= DOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic request_t random_request(logic [2:0] cmd);
    request_t r;
    r.command = cmd;
    r.index = 12'($urandom);
    r.bitmap_offset = 12'($urandom);
    r.glyph_width = 5'($urandom);
    r.glyph_height = 5'($urandom);
    r.x_advance = 5'($urandom);
    r.x_offset = 6'($urandom);
    r.y_offset = 6'($urandom);
    r.data_byte = 8'($urandom);
    r.column_word = 16'($urandom);
    r.write_mode = 2'($urandom);
    return r;
  endfunction

  // Hold a request until it is taken; idle first at random
  task automatic send(request_t r);
    while ($urandom_range(0, 99) < tx_idle) begin
      in_ch.valid <= 0;
      @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.command <= r.command;
    in_ch.index <= r.index;
    in_ch.bitmap_offset <= r.bitmap_offset;
    in_ch.glyph_width <= r.glyph_width;
    in_ch.glyph_height <= r.glyph_height;
    in_ch.x_advance <= r.x_advance;
    in_ch.x_offset <= r.x_offset;
    in_ch.y_offset <= r.y_offset;
    in_ch.data_byte <= r.data_byte;
    in_ch.column_word <= r.column_word;
    in_ch.write_mode <= r.write_mode;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    sb.note_request(r);
  endtask

  // Load a glyph record and its bitmap bytes where not yet written
  task automatic load_glyph(int gi);
    request_t r;
    int nbytes, a;
    if (!sb.glyph_loaded[gi]) begin
      r = random_request(gcr_pkg::CMD_GLYPH);
      r.index = 12'(gi);
      if ($urandom_range(0, 9) != 0) r.bitmap_offset = 12'($urandom_range(0, 31));
      if ($urandom_range(0, 9) != 0) begin
        r.glyph_width = 5'($urandom_range(0, 12));
        r.glyph_height = 5'($urandom_range(0, 16));
        r.x_advance = 5'($urandom_range(0, 12));
        r.x_offset = 6'($urandom_range(0, 4) - 2);
        r.y_offset = 6'($urandom_range(0, 6) - 5);
      end
      send(r);
    end
    nbytes = (int'(sb.glyphs[gi].width) * int'(sb.glyphs[gi].height) + 7) / 8;
    for (int i = 0; i < nbytes; i++) begin
      a = (int'(sb.glyphs[gi].offset) + i) % gcr_pkg::BITMAP_DEPTH;
      if (!sb.byte_loaded[a]) begin
        r = random_request(gcr_pkg::CMD_BITMAP);
        r.index = 12'(a);
        send(r);
      end
    end
  endtask

  task automatic send_char(logic [7:0] c, logic [1:0] mode);
    request_t r;
    int gi;
    gi = sb.glyph_for(c);
    if (gi >= 0) load_glyph(gi);
    r = random_request(gcr_pkg::CMD_CHAR);
    r.data_byte = c;
    r.write_mode = mode;
    send(r);
  endtask

  task automatic send_simple(logic [2:0] cmd, logic [11:0] idx, logic [15:0] w,
                             logic [1:0] mode);
    request_t r;
    r = random_request(cmd);
    r.index = idx;
    r.column_word = w;
    r.write_mode = mode;
    send(r);
  endtask

  // Write all registers while the block is idle
  task automatic write_regs(logic [7:0] pc, logic [7:0] fc, logic [7:0] lc, logic fp);
    logic [7:0] vals [4];
    vals = '{pc, fc, lc, {7'd0, fp}};
    in_ch.valid <= 0;
    while (sb.columns_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1;
      cfg_index <= i[1:0];
      cfg_data <= vals[i];
      @(posedge clk);
      sb.set_reg(i[1:0], vals[i]);
    end
    cfg_we <= 0;
  endtask

  task automatic directed_requests();
    request_t r;
    send_simple(gcr_pkg::CMD_RAW, 12'd0, 16'hffff, gcr_pkg::MODE_OVER);
    send_simple(gcr_pkg::CMD_RAW, 12'd0, 16'h0000, gcr_pkg::MODE_OR);
    send_simple(gcr_pkg::CMD_RAW, 12'd0, 16'hffff, gcr_pkg::MODE_ANDN);
    send_simple(gcr_pkg::CMD_RAW, 12'd0, 16'h1234, MODE_KEEP);
    send_simple(gcr_pkg::CMD_CURSOR, 12'd127, 16'h0, gcr_pkg::MODE_OVER);
    send_simple(gcr_pkg::CMD_RAW, 12'd0, 16'ha5a5, gcr_pkg::MODE_OVER);
    send_simple(gcr_pkg::CMD_CURSOR, 12'd4095, 16'h0, gcr_pkg::MODE_OVER);
    send_simple(gcr_pkg::CMD_GLYPH, 12'd4095, 16'h0, gcr_pkg::MODE_OVER);
    send_simple(CMD_BAD, 12'd0, 16'h0, gcr_pkg::MODE_OVER);
    // Glyph whose bitmap wraps past the end of the store
    r = random_request(gcr_pkg::CMD_GLYPH);
    r.index = 12'(gcr_pkg::CH_UA - 8'd32);
    r.bitmap_offset = 12'd4095;
    r.glyph_width = 5'd16;
    r.glyph_height = 5'd4;
    r.x_advance = 5'd24;
    r.x_offset = -6'sd8;
    r.y_offset = -6'sd11;
    send(r);
    send_char(gcr_pkg::CH_UA, gcr_pkg::MODE_OVER);
    send_char(gcr_pkg::UTF8_LEAD, gcr_pkg::MODE_OVER);
    send_char(gcr_pkg::CH_A_UML, gcr_pkg::MODE_OR);
    send_char(gcr_pkg::UTF8_LEAD, gcr_pkg::MODE_OVER);
    send_char(gcr_pkg::CH_ESZETT, gcr_pkg::MODE_OVER);
    send_char(gcr_pkg::UTF8_LEAD, gcr_pkg::MODE_OVER);
    send_char(gcr_pkg::UTF8_LEAD, gcr_pkg::MODE_OVER);
    send_char(gcr_pkg::CH_UU_UML, gcr_pkg::MODE_ANDN);
    send_char(gcr_pkg::UTF8_LEAD, gcr_pkg::MODE_OVER);
    send_char(8'h78, gcr_pkg::MODE_OVER);
    send_char(8'h7f, gcr_pkg::MODE_OVER);
    send_char(gcr_pkg::UTF8_LEAD, gcr_pkg::MODE_OVER);
    send_char(gcr_pkg::CH_OU_UML, MODE_KEEP);
    send_char(gcr_pkg::UTF8_LEAD, gcr_pkg::MODE_OVER);
    send_char(gcr_pkg::CH_AU_UML, gcr_pkg::MODE_OVER);
  endtask

  task automatic random_requests(int count);
    int pick, lo, hi;
    logic [7:0] ch;
    logic [7:0] umlauts [7];
    umlauts = '{gcr_pkg::CH_A_UML, gcr_pkg::CH_O_UML, gcr_pkg::CH_U_UML, gcr_pkg::CH_AU_UML,
                gcr_pkg::CH_OU_UML, gcr_pkg::CH_UU_UML, gcr_pkg::CH_ESZETT};
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        lo = sb.first_code;
        hi = sb.last_code;
        if ($urandom_range(0, 4) == 0) begin
          send_char(gcr_pkg::UTF8_LEAD, 2'($urandom));
          ch = ($urandom_range(0, 4) == 0) ? 8'($urandom) : umlauts[$urandom_range(0, 6)];
        end else if (lo <= hi && $urandom_range(0, 4) != 0) begin
          ch = 8'($urandom_range(lo, hi));
        end else begin
          ch = 8'($urandom);
        end
        send_char(ch, 2'($urandom));
      end else if (pick < 60) begin
        load_glyph($urandom_range(0, gcr_pkg::GLYPH_COUNT - 1));
      end else if (pick < 66) begin
        send_simple(gcr_pkg::CMD_BITMAP, 12'($urandom), 16'h0, gcr_pkg::MODE_OVER);
      end else if (pick < 82) begin
        send_simple(gcr_pkg::CMD_RAW, 12'd0, 16'($urandom), 2'($urandom));
      end else if (pick < 92) begin
        send_simple(gcr_pkg::CMD_CURSOR,
                    ($urandom_range(0, 2) == 0) ? 12'($urandom) : 12'($urandom_range(0, 140)),
                    16'h0, gcr_pkg::MODE_OVER);
      end else begin
        send_simple(3'($urandom_range(5, 7)), 12'($urandom), 16'($urandom), 2'($urandom));
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Default font range with the full ring
    tx_idle = 29;
    rx_idle = 48;
    write_regs(8'd128, 8'd32, 8'd126, 1'b1);
    directed_requests();
    random_requests(15);

    // Oversized ring length and the widest code range
    tx_idle = 48;
    rx_idle = 29;
    write_regs(8'd255, 8'd0, 8'd255, 1'b1);
    random_requests(20);

    // Short ring and a narrow range
    tx_idle = 0;
    rx_idle = 0;
    write_regs(8'd13, 8'd65, 8'd122, 1'b1);
    random_requests(20);

    // No font, ring length zero
    write_regs(8'd0, 8'd255, 8'd0, 1'b0);
    random_requests(10);
    write_regs(8'd1, 8'd32, 8'd126, 1'b1);
    random_requests(5);

    // Drain and report
    in_ch.valid <= 0;
    while (sb.columns_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.errors == 0 && sb.columns_due.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
